>>> hdl/ftwl_pkg.sv
// Package for the wildcard flow table lookup block.
// Holds codes, item and entry layouts, controller state and command/status structs.
// No dependencies.
package ftwl_pkg;

    typedef enum logic [0:0] {
        OP_ADD    = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_ADDED = 2'd0,
        ST_FULL  = 2'd1,
        ST_HIT   = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_WALK,
        S_ORD,
        S_ENT,
        S_COPY,
        S_COPYW,
        S_RESP
    } state_t;

    typedef struct packed {
        logic        operation;
        logic [31:0] now;
        logic [15:0] in_port;
        logic [15:0] eth_type;
        logic [47:0] eth_src;
        logic [47:0] eth_dst;
        logic [3:0]  wildcard_mask;
        logic [15:0] idle_timeout;
        logic [31:0] expires_at;
    } item_t;

    typedef struct packed {
        logic [3:0]  mask;
        logic [15:0] port;
        logic [15:0] etype;
        logic [47:0] src;
        logic [47:0] dst;
        logic [15:0] idle;
    } entry_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  slot;
        logic [31:0] new_expiry;
    } result_t;

    typedef struct packed {
        logic capture;
        logic scan_clr;
        logic scan_next;
        logic do_add;
        logic set_full;
        logic walk_init;
        logic ord_rd;
        logic ent_rd;
        logic drop;
        logic keep;
        logic hit;
        logic copy_wr;
        logic commit;
        logic set_miss;
        logic res_load;
    } cmd_t;

    typedef struct packed {
        logic is_add;
        logic full;
        logic slot_used;
        logic walk_end;
        logic expired;
        logic match;
        logic res_busy;
    } sts_t;

endpackage

>>> hdl/ftwl_if.sv
// Handshake interfaces for request and response items.
// Depends on nothing; payload widths are fixed.
interface ftwl_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] now;
    logic [15:0] in_port;
    logic [15:0] eth_type;
    logic [47:0] eth_src;
    logic [47:0] eth_dst;
    logic [3:0]  wildcard_mask;
    logic [15:0] idle_timeout;
    logic [31:0] expires_at;

    modport source (output valid, operation, now, in_port, eth_type, eth_src, eth_dst,
                    wildcard_mask, idle_timeout, expires_at, input ready);
    modport sink (input valid, operation, now, in_port, eth_type, eth_src, eth_dst,
                  wildcard_mask, idle_timeout, expires_at, output ready);
endinterface

interface ftwl_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [31:0] new_expiry;

    modport source (output valid, status, slot, new_expiry, input ready);
    modport sink (input valid, status, slot, new_expiry, output ready);
endinterface

>>> hdl/ftwl_ctrl.sv
// Sequencer for add and lookup items.
// Depends on ftwl_pkg (state, command and status types).
module ftwl_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ftwl_pkg::sts_t sts,
    output ftwl_pkg::cmd_t cmd
);
    import ftwl_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (req_valid) state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                if (sts.is_add)
                    state_next = sts.full ? S_RESP : S_SCAN;
                else
                    state_next = S_WALK;
            end
            S_SCAN:     if (!sts.slot_used) state_next = S_RESP;
            S_WALK:     state_next = sts.walk_end ? S_RESP : S_ORD;
            S_ORD:      state_next = S_ENT;
            S_ENT:
            begin
                if (sts.expired)
                    state_next = S_WALK;
                else if (sts.match)
                    state_next = S_COPY;
                else
                    state_next = S_WALK;
            end
            S_COPY:     state_next = sts.walk_end ? S_RESP : S_COPYW;
            S_COPYW:    state_next = S_COPY;
            S_RESP:     if (!sts.res_busy) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            S_DISPATCH:
            begin
                if (sts.is_add)
                begin
                    cmd.set_full = sts.full;
                    cmd.scan_clr = !sts.full;
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                end
            end
            S_SCAN:
            begin
                cmd.do_add    = !sts.slot_used;
                cmd.scan_next = sts.slot_used;
            end
            S_WALK:
            begin
                cmd.commit   = sts.walk_end;
                cmd.set_miss = sts.walk_end;
                cmd.ord_rd   = !sts.walk_end;
            end
            S_ORD:      cmd.ent_rd = 1'b1;
            S_ENT:
            begin
                cmd.drop = sts.expired;
                cmd.hit  = !sts.expired && sts.match;
                cmd.keep = !sts.expired && !sts.match;
            end
            S_COPY:
            begin
                cmd.commit = sts.walk_end;
                cmd.ord_rd = !sts.walk_end;
            end
            S_COPYW:    cmd.copy_wr = 1'b1;
            S_RESP:     cmd.res_load = !sts.res_busy;
            default:    cmd = '0;
        endcase
    end

endmodule

>>> hdl/ftwl_datapath.sv
// Table storage, recency ring, walk indices and result registers.
// Depends on ftwl_pkg (item, entry, result, command and status types).
module ftwl_datapath #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ftwl_pkg::item_t   item,
    input  ftwl_pkg::cmd_t    cmd,
    output ftwl_pkg::sts_t    sts,
    input  logic              rsp_ready,
    output logic              rsp_valid,
    output ftwl_pkg::result_t rsp_data
);
    import ftwl_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // memories
    entry_t      ent_mem [TABLE_DEPTH];
    logic [31:0] exp_mem [TABLE_DEPTH];
    logic [AW-1:0] ord_mem [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] r_reg;
    logic [CW-1:0] w_reg;
    logic [AW-1:0] idx_reg;

    item_t         item_reg;
    logic [AW-1:0] ord_q;
    logic [AW-1:0] s_reg;
    entry_t        ent_q;
    logic [31:0]   exp_q;
    result_t       pend_reg;
    result_t       res_reg;
    logic          res_valid_reg;

    logic [AW:0]   sum_r, sum_w;
    logic [AW-1:0] pos_r, pos_w, head_dec;
    logic [32:0]   refresh_sum;
    logic [31:0]   new_exp;
    logic [AW+5:0] idx_ext, s_ext;
    logic          ord_we;
    logic [AW-1:0] ord_wa, ord_wd;

    // ring positions, head + offset modulo depth
    assign sum_r = {1'b0, head_reg} + {1'b0, r_reg[AW-1:0]};
    assign sum_w = {1'b0, head_reg} + {1'b0, w_reg[AW-1:0]};
    assign pos_r = (sum_r >= (AW+1)'(TABLE_DEPTH)) ? AW'(sum_r - (AW+1)'(TABLE_DEPTH))
                                                   : sum_r[AW-1:0];
    assign pos_w = (sum_w >= (AW+1)'(TABLE_DEPTH)) ? AW'(sum_w - (AW+1)'(TABLE_DEPTH))
                                                   : sum_w[AW-1:0];
    assign head_dec = (head_reg == '0) ? AW'(TABLE_DEPTH - 1) : head_reg - 1'b1;

    assign refresh_sum = {1'b0, item_reg.now} + {17'b0, ent_q.idle};
    assign new_exp = (ent_q.idle == '0) ? exp_q :
                     (refresh_sum[32] ? 32'hFFFF_FFFF : refresh_sum[31:0]);

    assign idx_ext = {6'b0, idx_reg};
    assign s_ext   = {6'b0, s_reg};

    always_comb
    begin
        sts.is_add    = (item_reg.operation == OP_ADD);
        sts.full      = (count_reg >= CW'(TABLE_DEPTH));
        sts.slot_used = valid_reg[idx_reg];
        sts.walk_end  = (r_reg == count_reg);
        sts.expired   = (exp_q < item_reg.now);
        sts.match     = (ent_q.mask[0] || ent_q.port  == item_reg.in_port)  &&
                        (ent_q.mask[1] || ent_q.etype == item_reg.eth_type) &&
                        (ent_q.mask[2] || ent_q.src   == item_reg.eth_src)  &&
                        (ent_q.mask[3] || ent_q.dst   == item_reg.eth_dst);
        sts.res_busy  = res_valid_reg && !rsp_ready;
    end

    // recency ring write port
    always_comb
    begin
        ord_we = 1'b0;
        ord_wa = pos_w;
        ord_wd = s_reg;
        if (cmd.do_add)
        begin
            ord_we = 1'b1;
            ord_wa = head_dec;
            ord_wd = idx_reg;
        end
        else if (cmd.keep || cmd.hit)
        begin
            ord_we = 1'b1;
        end
        else if (cmd.copy_wr)
        begin
            ord_we = 1'b1;
            ord_wd = ord_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
            ord_mem[ord_wa] <= ord_wd;
        if (cmd.ord_rd)
            ord_q <= ord_mem[pos_r];
        if (cmd.do_add)
        begin
            ent_mem[idx_reg] <= '{mask: item_reg.wildcard_mask, port: item_reg.in_port,
                                  etype: item_reg.eth_type, src: item_reg.eth_src,
                                  dst: item_reg.eth_dst, idle: item_reg.idle_timeout};
        end
        if (cmd.ent_rd)
            ent_q <= ent_mem[ord_q];
        if (cmd.do_add)
            exp_mem[idx_reg] <= item_reg.expires_at;
        else if (cmd.hit)
            exp_mem[s_reg] <= new_exp;
        if (cmd.ent_rd)
            exp_q <= exp_mem[ord_q];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= item;
        if (cmd.ent_rd)
            s_reg <= ord_q;
        if (cmd.set_full)
            pend_reg <= '{status: ST_FULL, slot: 6'd0, new_expiry: 32'd0};
        else if (cmd.do_add)
            pend_reg <= '{status: ST_ADDED, slot: idx_ext[5:0], new_expiry: 32'd0};
        else if (cmd.hit)
            pend_reg <= '{status: ST_HIT, slot: s_ext[5:0], new_expiry: new_exp};
        else if (cmd.set_miss)
            pend_reg <= '{status: ST_MISS, slot: 6'd0, new_expiry: 32'd0};
        if (cmd.res_load)
            res_reg <= pend_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            r_reg         <= '0;
            w_reg         <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_clr)
                idx_reg <= '0;
            else if (cmd.scan_next)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.do_add)
            begin
                valid_reg[idx_reg] <= 1'b1;
                head_reg           <= head_dec;
                count_reg          <= count_reg + 1'b1;
            end
            if (cmd.walk_init)
            begin
                r_reg <= '0;
                w_reg <= '0;
            end
            if (cmd.drop)
            begin
                valid_reg[s_reg] <= 1'b0;
                r_reg            <= r_reg + 1'b1;
            end
            if (cmd.keep || cmd.hit || cmd.copy_wr)
            begin
                r_reg <= r_reg + 1'b1;
                w_reg <= w_reg + 1'b1;
            end
            if (cmd.commit)
                count_reg <= w_reg;
            if (cmd.res_load)
                res_valid_reg <= 1'b1;
            else if (rsp_ready)
                res_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = res_valid_reg;
    assign rsp_data  = res_reg;

endmodule

>>> hdl/flow_table_wildcard_lookup_core.sv
// Top level of the wildcard flow table lookup block.
// Depends on ftwl_pkg, ftwl_if, ftwl_ctrl and ftwl_datapath.
//
// Usage:
//   req  : request items (add entry or lookup query), valid/ready handshake.
//   rsp  : one result item per request, held in an output register until taken.
//   Add: the lowest free slot is found by a scan of the valid bits, one slot a
//   cycle; a full table is answered with no scan.
//   Lookup: the recency ring is walked newest first. Each examined entry takes a
//   ring read, an entry read and a compare; after a hit the remaining ring
//   entries are compacted, a read and a write each, to close gaps left by
//   expired ones.
//   One item is in work at a time; the next request is taken once the result
//   has been moved to the output register, even while that register still
//   waits for the receiver.
//   A stalled receiver holds the result and, once a second result is ready,
//   holds the sequencer until the first is taken.
//   Reset clears the valid bits, the ring head and the entry count at once; the
//   table is empty and ready for requests as soon as reset is released.
module flow_table_wildcard_lookup_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    ftwl_req_if.sink   req,
    ftwl_rsp_if.source rsp
);
    import ftwl_pkg::*;

    item_t   item;
    cmd_t    cmd;
    sts_t    sts;
    result_t res;
    logic    ready;

    // request payload into one word
    assign item = '{operation: req.operation, now: req.now, in_port: req.in_port,
                    eth_type: req.eth_type, eth_src: req.eth_src, eth_dst: req.eth_dst,
                    wildcard_mask: req.wildcard_mask, idle_timeout: req.idle_timeout,
                    expires_at: req.expires_at};
    assign req.ready = ready;

    ftwl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ftwl_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .rsp_data  (res)
    );

    assign rsp.status     = res.status;
    assign rsp.slot       = res.slot;
    assign rsp.new_expiry = res.new_expiry;

    // an occupied slot is never overwritten
    a_add_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_add |-> !sts.slot_used)
        else $error("add into occupied slot");

    // a hit is only taken on a live, matching entry
    a_hit_live: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hit |-> (!sts.expired && sts.match))
        else $error("hit on expired or mismatching entry");

    // at most one ring command (add, keep, hit, copy, drop) at a time
    a_ring_wr: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.do_add, cmd.keep, cmd.hit, cmd.copy_wr, cmd.drop}))
        else $error("conflicting ring commands");

    // a held result is never overwritten
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> !(rsp.valid && !rsp.ready))
        else $error("result overwritten while stalled");

    // captures of new requests are never back to back
    a_cap_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> !cmd.capture)
        else $error("back to back capture");

endmodule
